// File: rtl/core/idll_pkg.sv
// idll_pkg: shared widths, codes and bundle types of the linked list manager
// no dependencies; used by idll_ctrl, the top level, the checker and the bench
package idll_pkg;

	localparam int NODE_COUNT = 1024;
	localparam int LIST_COUNT = 8;
	localparam int IDX_W      = $clog2(NODE_COUNT);
	localparam int LINK_W     = IDX_W + 1;
	localparam int LIST_W     = $clog2(LIST_COUNT);
	localparam int CNT_W      = LINK_W;
	localparam int KIND_W     = 3;
	localparam int STAT_W     = 2;

	typedef logic [IDX_W-1:0]  idx_t;
	typedef logic [LINK_W-1:0] link_t;
	typedef logic [LIST_W-1:0] list_t;
	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [KIND_W-1:0] kind_t;
	typedef logic [STAT_W-1:0] stat_t;

	// link value that points nowhere
	localparam link_t NIL = link_t'(NODE_COUNT);
	localparam cnt_t MAX_SIZE_RESET = cnt_t'(NODE_COUNT);

	// operation codes
	localparam kind_t KIND_INS_HEAD = 3'd0;
	localparam kind_t KIND_INS_TAIL = 3'd1;
	localparam kind_t KIND_RM_ITEM  = 3'd2;
	localparam kind_t KIND_RM_HEAD  = 3'd3;
	localparam kind_t KIND_RM_TAIL  = 3'd4;

	// status codes
	localparam stat_t STATUS_OK    = 2'd0;
	localparam stat_t STATUS_FULL  = 2'd1;
	localparam stat_t STATUS_EMPTY = 2'd2;

	// one access to a link memory: write port plus read address
	typedef struct packed {
		logic  we;
		idx_t  waddr;
		link_t wdata;
		idx_t  raddr;
	} link_req_t;

	// one finished result item
	typedef struct packed {
		idx_t  removed_index;
		logic  removed_valid;
		stat_t status;
		cnt_t  list_size;
	} result_t;

endpackage

// File: rtl/core/idll_ram.sv
// idll_ram: generic single-write, single-read RAM with registered read data
// no dependencies
module idll_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/core/idll_ctrl.sv
// idll_ctrl: operation sequencer, list head and size registers
// depends on idll_pkg; drives the prev and next link memories
module idll_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  idll_pkg::kind_t     kind,
	input  idll_pkg::list_t     list_id,
	input  idll_pkg::idx_t      item_index,
	input  idll_pkg::cnt_t      max_size,
	output idll_pkg::link_req_t prev_req,
	output idll_pkg::link_req_t next_req,
	input  idll_pkg::link_t     prev_rdata,
	input  idll_pkg::link_t     next_rdata,
	output idll_pkg::result_t   res,
	output logic                res_valid,
	input  logic                res_ready
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_INS_WAIT,
		S_INS_LINK,
		S_RM_HEAD,
		S_RM_ITEM,
		S_RM_CLR,
		S_DONE
	} state_t;

	state_t           state_q;
	idll_pkg::kind_t  kind_q;
	idll_pkg::list_t  list_q;
	idll_pkg::idx_t   item_q;
	idll_pkg::link_t  head_q  [idll_pkg::LIST_COUNT];
	idll_pkg::cnt_t   count_q [idll_pkg::LIST_COUNT];
	idll_pkg::link_t  last_q;
	idll_pkg::idx_t   target_q;
	idll_pkg::idx_t   rm_index_q;
	logic             rm_valid_q;
	idll_pkg::stat_t  status_q;

	idll_pkg::link_t  cur_head;
	idll_pkg::cnt_t   cur_count;
	idll_pkg::link_t  item_link;
	idll_pkg::idx_t   tgt_c;
	logic             full_c;
	logic             empty_c;

	// current list view and decisions
	always_comb begin
		cur_head  = head_q[list_q];
		cur_count = count_q[list_q];
		item_link = {1'b0, item_q};
		full_c    = (cur_count >= max_size);
		empty_c   = (cur_count == '0) || (cur_head == idll_pkg::NIL);
		case (kind_q)
			idll_pkg::KIND_RM_ITEM: tgt_c = item_q;
			idll_pkg::KIND_RM_HEAD: tgt_c = cur_head[idll_pkg::IDX_W-1:0];
			default:                tgt_c = prev_rdata[idll_pkg::IDX_W-1:0];
		endcase
	end

	// link memory accesses
	always_comb begin
		prev_req       = '0;
		next_req       = '0;
		prev_req.raddr = (state_q == S_RM_HEAD) ? tgt_c : cur_head[idll_pkg::IDX_W-1:0];
		next_req.raddr = prev_req.raddr;
		case (state_q)
			S_CHECK: begin
				// first node of an empty ring points at itself
				if ((kind_q == idll_pkg::KIND_INS_HEAD || kind_q == idll_pkg::KIND_INS_TAIL)
						&& !full_c && cur_head == idll_pkg::NIL) begin
					prev_req.we    = 1'b1;
					prev_req.waddr = item_q;
					prev_req.wdata = item_link;
					next_req.we    = 1'b1;
					next_req.waddr = item_q;
					next_req.wdata = item_link;
				end
			end
			S_INS_WAIT: begin
				prev_req.we    = 1'b1;
				prev_req.waddr = item_q;
				prev_req.wdata = prev_rdata;
				next_req.we    = 1'b1;
				next_req.waddr = item_q;
				next_req.wdata = cur_head;
			end
			S_INS_LINK: begin
				prev_req.we    = 1'b1;
				prev_req.waddr = cur_head[idll_pkg::IDX_W-1:0];
				prev_req.wdata = item_link;
				next_req.we    = (last_q < idll_pkg::NIL);
				next_req.waddr = last_q[idll_pkg::IDX_W-1:0];
				next_req.wdata = item_link;
			end
			S_RM_ITEM: begin
				// bridge the neighbors of the removed node
				next_req.we    = (prev_rdata < idll_pkg::NIL);
				next_req.waddr = prev_rdata[idll_pkg::IDX_W-1:0];
				next_req.wdata = next_rdata;
				prev_req.we    = (next_rdata < idll_pkg::NIL);
				prev_req.waddr = next_rdata[idll_pkg::IDX_W-1:0];
				prev_req.wdata = prev_rdata;
			end
			S_RM_CLR: begin
				prev_req.we    = 1'b1;
				prev_req.waddr = target_q;
				prev_req.wdata = idll_pkg::NIL;
				next_req.we    = 1'b1;
				next_req.waddr = target_q;
				next_req.wdata = idll_pkg::NIL;
			end
			default: begin
			end
		endcase
	end

	// sequencer, list registers and result fields
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			kind_q     <= '0;
			list_q     <= '0;
			item_q     <= '0;
			last_q     <= '0;
			target_q   <= '0;
			rm_index_q <= '0;
			rm_valid_q <= 1'b0;
			status_q   <= idll_pkg::STATUS_OK;
			for (int i = 0; i < idll_pkg::LIST_COUNT; i++) begin
				head_q[i]  <= idll_pkg::NIL;
				count_q[i] <= '0;
			end
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						kind_q  <= kind;
						list_q  <= list_id;
						item_q  <= item_index;
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					rm_index_q <= '0;
					rm_valid_q <= 1'b0;
					status_q   <= idll_pkg::STATUS_OK;
					unique case (kind_q) inside
						idll_pkg::KIND_INS_HEAD, idll_pkg::KIND_INS_TAIL: begin
							if (full_c) begin
								status_q <= idll_pkg::STATUS_FULL;
								state_q  <= S_DONE;
							end else if (cur_head == idll_pkg::NIL) begin
								head_q[list_q]  <= item_link;
								count_q[list_q] <= cur_count + 1'b1;
								state_q         <= S_DONE;
							end else begin
								state_q <= S_INS_WAIT;
							end
						end
						idll_pkg::KIND_RM_ITEM, idll_pkg::KIND_RM_HEAD,
						idll_pkg::KIND_RM_TAIL: begin
							if (empty_c) begin
								status_q <= idll_pkg::STATUS_EMPTY;
								state_q  <= S_DONE;
							end else begin
								state_q <= S_RM_HEAD;
							end
						end
						default: begin
							state_q <= S_DONE;
						end
					endcase
				end
				S_INS_WAIT: begin
					last_q  <= prev_rdata;
					state_q <= S_INS_LINK;
				end
				S_INS_LINK: begin
					if (kind_q == idll_pkg::KIND_INS_HEAD) begin
						head_q[list_q] <= item_link;
					end
					count_q[list_q] <= cur_count + 1'b1;
					state_q         <= S_DONE;
				end
				S_RM_HEAD: begin
					// head links are on the read port now
					target_q <= tgt_c;
					if (kind_q == idll_pkg::KIND_RM_TAIL && prev_rdata == idll_pkg::NIL) begin
						status_q <= idll_pkg::STATUS_EMPTY;
						state_q  <= S_DONE;
					end else if (prev_rdata == cur_head && next_rdata == cur_head) begin
						head_q[list_q] <= idll_pkg::NIL;
						state_q        <= S_RM_CLR;
					end else begin
						state_q <= S_RM_ITEM;
					end
				end
				S_RM_ITEM: begin
					if ({1'b0, target_q} == cur_head) begin
						head_q[list_q] <= next_rdata;
					end
					state_q <= S_RM_CLR;
				end
				S_RM_CLR: begin
					count_q[list_q] <= cur_count - 1'b1;
					rm_valid_q      <= 1'b1;
					rm_index_q      <= target_q;
					state_q         <= S_DONE;
				end
				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// result item and input stall
	always_comb begin
		res.removed_index = rm_index_q;
		res.removed_valid = rm_valid_q;
		res.status        = status_q;
		res.list_size     = cur_count;
	end

	assign res_valid = (state_q == S_DONE);
	assign in_stall  = (state_q != S_IDLE);

endmodule

// File: rtl/core/indexed_doubly_linked_list_manager.sv
// indexed_doubly_linked_list_manager: top level, link memories and output register
// depends on idll_pkg, idll_ram and idll_ctrl
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_stall  kind, list_id, item_index
//   out      output     out_valid/out_stall  removed_index, removed_valid, status, list_size
//   cfg      input      cfg_valid/cfg_ready  cfg_data (max_list_size)
//
// An item passes S_CHECK, then S_DONE: an unknown kind, a refusal at the size or empty check
// or an insert into an empty list goes straight on, an insert into a non-empty list passes
// S_INS_WAIT and S_INS_LINK, a removal S_RM_HEAD, then S_RM_ITEM unless it empties a one-node
// ring, then S_RM_CLR, and a tail removal refused on a nil tail link stops after S_RM_HEAD.
// Reset clears the head and size registers at once; the link memories are not cleared.
// A stalled result waits in the output register while the next item is taken and worked on.
module indexed_doubly_linked_list_manager (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  idll_pkg::kind_t      kind,
	input  idll_pkg::list_t      list_id,
	input  idll_pkg::idx_t       item_index,
	output logic                 out_valid,
	input  logic                 out_stall,
	output idll_pkg::idx_t       removed_index,
	output logic                 removed_valid,
	output idll_pkg::stat_t      status,
	output idll_pkg::cnt_t       list_size,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  idll_pkg::cnt_t       cfg_data
);

	idll_pkg::cnt_t      max_size_q;
	idll_pkg::link_req_t prev_req;
	idll_pkg::link_req_t next_req;
	idll_pkg::link_t     prev_rdata;
	idll_pkg::link_t     next_rdata;
	idll_pkg::result_t   res;
	logic                res_valid;
	logic                res_ready;
	logic                out_valid_q;
	idll_pkg::result_t   out_q;

	// size limit register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_size_q <= idll_pkg::MAX_SIZE_RESET;
		end else if (cfg_valid) begin
			max_size_q <= cfg_data;
		end
	end

	idll_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.kind       (kind),
		.list_id    (list_id),
		.item_index (item_index),
		.max_size   (max_size_q),
		.prev_req   (prev_req),
		.next_req   (next_req),
		.prev_rdata (prev_rdata),
		.next_rdata (next_rdata),
		.res        (res),
		.res_valid  (res_valid),
		.res_ready  (res_ready)
	);

	idll_ram #(
		.WIDTH (idll_pkg::LINK_W),
		.DEPTH (idll_pkg::NODE_COUNT)
	) u_prev_ram (
		.clk   (clk),
		.we    (prev_req.we),
		.waddr (prev_req.waddr),
		.wdata (prev_req.wdata),
		.raddr (prev_req.raddr),
		.rdata (prev_rdata)
	);

	idll_ram #(
		.WIDTH (idll_pkg::LINK_W),
		.DEPTH (idll_pkg::NODE_COUNT)
	) u_next_ram (
		.clk   (clk),
		.we    (next_req.we),
		.waddr (next_req.waddr),
		.wdata (next_req.wdata),
		.raddr (next_req.raddr),
		.rdata (next_rdata)
	);

	// output register
	assign res_ready = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign out_valid     = out_valid_q;
	assign removed_index = out_q.removed_index;
	assign removed_valid = out_q.removed_valid;
	assign status        = out_q.status;
	assign list_size     = out_q.list_size;

endmodule

// File: rtl/core/idll_checker.sv
// idll_checker: port-level assertions for the linked list manager, bound to the top level
// depends on idll_pkg and indexed_doubly_linked_list_manager
module idll_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            in_valid,
	input logic            in_stall,
	input logic            out_valid,
	input logic            out_stall,
	input idll_pkg::idx_t  removed_index,
	input logic            removed_valid,
	input idll_pkg::stat_t status,
	input idll_pkg::cnt_t  list_size
);

	// a stalled result item stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result item dropped while stalled");

	// a stalled result item keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(removed_index) && $stable(removed_valid)
			&& $stable(status) && $stable(list_size))
		else $error("result payload changed while stalled");

	// an accepted item keeps the input stalled while it is worked on
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while an item is in work");

	// a removed node only comes with an OK status
	a_rm_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && removed_valid |-> status == idll_pkg::STATUS_OK)
		else $error("removed node reported with a refusal");

endmodule

bind indexed_doubly_linked_list_manager idll_checker u_idll_checker (.*);

// File: bench/indexed_doubly_linked_list_manager_tb.sv
// indexed_doubly_linked_list_manager_tb: self-checking bench for the linked list manager
// depends on idll_pkg and indexed_doubly_linked_list_manager; a directed table, then random
// phases over several size limits, each result item checked against a table row or a predictor
module indexed_doubly_linked_list_manager_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import idll_pkg::*;

	// kinds outside the five operations
	localparam kind_t KIND_SPARE_LO = 3'd5;
	localparam kind_t KIND_SPARE_HI = 3'd7;

	localparam int PHASE_ITEMS    = 200;
	localparam int PHASE_COUNT    = 6;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 20;

	// one row of the directed plan
	typedef struct packed {
		kind_t   k;
		list_t   l;
		idx_t    ix;
		logic    known;
		result_t res;
	} plan_row_t;

	logic    clk = 1'b0;
	logic    arst_n;
	logic    in_valid;
	logic    in_stall;
	kind_t   kind;
	list_t   list_id;
	idx_t    item_index;
	logic    out_valid;
	logic    out_stall;
	idx_t    removed_index;
	logic    removed_valid;
	stat_t   status;
	cnt_t    list_size;
	logic    cfg_valid;
	logic    cfg_ready;
	cnt_t    cfg_data;

	// result items still owed by the block, oldest first
	result_t   pending_results [$];
	plan_row_t plan_q [$];
	cnt_t      phase_limits [PHASE_COUNT];
	int        errors;
	int        in_burst;

	// predicted list state
	link_t head_ptr [LIST_COUNT];
	cnt_t  node_total [LIST_COUNT];
	link_t prev_of [NODE_COUNT];
	link_t next_of [NODE_COUNT];
	cnt_t  size_limit;

	// which nodes hold links and which sit in a list, for choosing stimulus
	bit    in_use [NODE_COUNT];
	bit    linked_once [NODE_COUNT];
	idx_t  linked_nodes [$];
	int    in_use_count;

	indexed_doubly_linked_list_manager dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.kind          (kind),
		.list_id       (list_id),
		.item_index    (item_index),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.removed_index (removed_index),
		.removed_valid (removed_valid),
		.status        (status),
		.list_size     (list_size),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// link access, with nil reading as nil and writes to nil dropped
	function automatic link_t get_prev(link_t n);
		return (n < NIL) ? prev_of[idx_t'(n)] : NIL;
	endfunction

	function automatic link_t get_next(link_t n);
		return (n < NIL) ? next_of[idx_t'(n)] : NIL;
	endfunction

	function automatic void put_prev(link_t n, link_t v);
		if (n < NIL) prev_of[idx_t'(n)] = v;
	endfunction

	function automatic void put_next(link_t n, link_t v);
		if (n < NIL) next_of[idx_t'(n)] = v;
	endfunction

	// splice a node in just before the head
	function automatic void ring_append(list_t l, idx_t item);
		link_t h;
		link_t last;
		link_t it;
		h  = head_ptr[l];
		it = link_t'(item);
		if (h == NIL) begin
			put_prev(it, it);
			put_next(it, it);
			head_ptr[l] = it;
		end else begin
			last = get_prev(h);
			put_prev(it, last);
			put_next(it, h);
			put_prev(h, it);
			put_next(last, it);
		end
	endfunction

	// take a node out of the ring and clear its links
	function automatic void ring_unlink(list_t l, link_t t);
		link_t h;
		link_t p;
		link_t n;
		h = head_ptr[l];
		if (get_prev(h) == h && get_next(h) == h) begin
			head_ptr[l] = NIL;
		end else begin
			p = get_prev(t);
			n = get_next(t);
			put_next(p, n);
			put_prev(n, p);
			if (t == h) head_ptr[l] = n;
		end
		put_prev(t, NIL);
		put_next(t, NIL);
	endfunction

	// expected result of one operation, updating the predicted state
	function automatic result_t predict_op(kind_t k, list_t l, idx_t ix);
		result_t r;
		link_t   target;
		r = '0;
		r.status = STATUS_OK;
		case (k)
			KIND_INS_HEAD, KIND_INS_TAIL: begin
				if (node_total[l] >= size_limit) begin
					r.status = STATUS_FULL;
				end else begin
					ring_append(l, ix);
					if (k == KIND_INS_HEAD) head_ptr[l] = link_t'(ix);
					node_total[l] = node_total[l] + 1'b1;
				end
			end
			KIND_RM_ITEM, KIND_RM_HEAD, KIND_RM_TAIL: begin
				target = NIL;
				if (node_total[l] != '0 && head_ptr[l] != NIL) begin
					if (k == KIND_RM_ITEM) target = link_t'(ix);
					else if (k == KIND_RM_HEAD) target = head_ptr[l];
					else target = get_prev(head_ptr[l]);
				end
				if (target == NIL) begin
					r.status = STATUS_EMPTY;
				end else begin
					ring_unlink(l, target);
					node_total[l] = node_total[l] - 1'b1;
					r.removed_valid = 1'b1;
					r.removed_index = idx_t'(target);
				end
			end
			default: ;
		endcase
		r.list_size = node_total[l];
		return r;
	endfunction

	task automatic reset_predictor();
		for (int i = 0; i < LIST_COUNT; i++) begin
			head_ptr[i]   = NIL;
			node_total[i] = '0;
		end
		for (int i = 0; i < NODE_COUNT; i++) begin
			prev_of[i]     = '0;
			next_of[i]     = '0;
			in_use[i]      = 1'b0;
			linked_once[i] = 1'b0;
		end
		size_limit   = MAX_SIZE_RESET;
		in_use_count = 0;
	endtask

	// item accepted: predict, keep the bookkeeping, queue what is owed
	task automatic accept_item(kind_t k, list_t l, idx_t ix, logic known, result_t known_res);
		result_t r;
		r = predict_op(k, l, ix);
		if ((k == KIND_INS_HEAD || k == KIND_INS_TAIL) && r.status == STATUS_OK) begin
			if (!in_use[ix]) in_use_count++;
			in_use[ix] = 1'b1;
			if (!linked_once[ix]) begin
				linked_once[ix] = 1'b1;
				linked_nodes.push_back(ix);
			end
		end
		if (r.removed_valid && in_use[r.removed_index]) begin
			in_use[r.removed_index] = 1'b0;
			in_use_count--;
		end
		pending_results.push_back(known ? known_res : r);
	endtask

	// random gap length: mostly short, a few long, with stretches of none
	task automatic draw_idle(inout int burst, output int len);
		int r;
		r = $urandom_range(0, 99);
		if (burst > 0) begin
			burst--;
			len = 0;
		end else if (r < 4) begin
			burst = $urandom_range(20, 60);
			len = 0;
		end else if (r < 50) len = 0;
		else if (r < 85) len = $urandom_range(1, 3);
		else if (r < 97) len = $urandom_range(4, 12);
		else len = $urandom_range(20, 60);
	endtask

	// present one item and hold it until it is taken
	task automatic send_item(kind_t k, list_t l, idx_t ix, logic known, result_t known_res);
		int gap;
		draw_idle(in_burst, gap);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		kind       <= k;
		list_id    <= l;
		item_index <= ix;
		do @(posedge clk); while (!(in_valid && !in_stall));
		accept_item(k, l, ix, known, known_res);
	endtask

	// new size limit, only once the block has drained
	task automatic write_limit(cnt_t v);
		while (pending_results.size() != 0) @(posedge clk);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		cfg_valid <= 1'b0;
		size_limit = v;
	endtask

	// node reached after a number of forward steps from the head
	function automatic idx_t ring_member(list_t l, int steps);
		link_t n;
		n = head_ptr[l];
		for (int s = 0; s < steps && get_next(n) != NIL; s++) n = get_next(n);
		return idx_t'(n);
	endfunction

	// prefer a node that sits in no list
	function automatic idx_t free_node();
		idx_t ix;
		ix = idx_t'($urandom_range(0, NODE_COUNT - 1));
		if ($urandom_range(0, 99) < 4) return ix;
		for (int t = 0; t < 8 && in_use[ix]; t++) ix = idx_t'($urandom_range(0, NODE_COUNT - 1));
		return ix;
	endfunction

	// random item: mostly well-formed list traffic, some noise
	task automatic pick_item(output kind_t k, output list_t l, output idx_t ix, output bit counted);
		int r;
		int ins_pct;
		l  = ($urandom_range(0, 9) < 7) ? list_t'($urandom_range(0, 2))
		                                 : list_t'($urandom_range(0, LIST_COUNT - 1));
		ix = idx_t'($urandom_range(0, NODE_COUNT - 1));
		counted = 1'b1;
		ins_pct = (in_use_count < 600) ? 55 : 25;
		r = $urandom_range(0, 99);
		if (r < 6) begin
			k = kind_t'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
			counted = 1'b0;
		end else if (r < 10 && linked_nodes.size() != 0) begin
			// removal of a node that may belong elsewhere
			k  = KIND_RM_ITEM;
			ix = linked_nodes[$urandom_range(0, linked_nodes.size() - 1)];
		end else if ((node_total[l] == '0 && r < 90) ||
		             (node_total[l] != '0 && $urandom_range(0, 99) < ins_pct)) begin
			k  = $urandom_range(0, 1) ? KIND_INS_HEAD : KIND_INS_TAIL;
			ix = free_node();
		end else begin
			case ($urandom_range(0, 2))
				0: k = KIND_RM_ITEM;
				1: k = KIND_RM_HEAD;
				default: k = KIND_RM_TAIL;
			endcase
			if (k == KIND_RM_ITEM && node_total[l] != '0)
				ix = ring_member(l, $urandom_range(0, node_total[l] - 1));
		end
	endtask

	task automatic plan_known(kind_t k, list_t l, idx_t ix, idx_t ridx, logic rv, stat_t st,
	                          cnt_t sz);
		plan_row_t row;
		row.k  = k;
		row.l  = l;
		row.ix = ix;
		row.known = 1'b1;
		row.res.removed_index = ridx;
		row.res.removed_valid = rv;
		row.res.status        = st;
		row.res.list_size     = sz;
		plan_q.push_back(row);
	endtask

	task automatic plan_pred(kind_t k, list_t l, idx_t ix);
		plan_row_t row;
		row = '0;
		row.k  = k;
		row.l  = l;
		row.ix = ix;
		plan_q.push_back(row);
	endtask

	task automatic build_plan();
		// removals and spare kinds right after reset
		plan_known(KIND_RM_HEAD,  3'd0, 10'd0,    10'd0, 1'b0, STATUS_EMPTY, 11'd0);
		plan_known(KIND_RM_TAIL,  3'd7, 10'd1023, 10'd0, 1'b0, STATUS_EMPTY, 11'd0);
		plan_known(KIND_RM_ITEM,  3'd3, 10'd1023, 10'd0, 1'b0, STATUS_EMPTY, 11'd0);
		plan_known(KIND_SPARE_LO, 3'd0, 10'd1023, 10'd0, 1'b0, STATUS_OK,    11'd0);
		plan_known(KIND_SPARE_HI, 3'd7, 10'd0,    10'd0, 1'b0, STATUS_OK,    11'd0);
		// extreme nodes in and out again
		plan_known(KIND_INS_HEAD, 3'd0, 10'd0,    10'd0, 1'b0, STATUS_OK, 11'd1);
		plan_known(KIND_INS_TAIL, 3'd0, 10'd1023, 10'd0, 1'b0, STATUS_OK, 11'd2);
		plan_known(KIND_INS_HEAD, 3'd7, 10'd512,  10'd0, 1'b0, STATUS_OK, 11'd1);
		plan_known(KIND_RM_TAIL,  3'd0, 10'd0,    10'd1023, 1'b1, STATUS_OK, 11'd1);
		plan_known(KIND_RM_HEAD,  3'd0, 10'd1023, 10'd0,    1'b1, STATUS_OK, 11'd0);
		plan_known(KIND_RM_HEAD,  3'd0, 10'd0,    10'd0,    1'b0, STATUS_EMPTY, 11'd0);
		// single-node ring empties whatever item is named
		plan_known(KIND_RM_ITEM,  3'd7, 10'd0,    10'd0,    1'b1, STATUS_OK, 11'd0);
		// three-node ring, middle removal, removal of a node with nil links
		plan_pred(KIND_INS_TAIL, 3'd1, 10'd10);
		plan_pred(KIND_INS_TAIL, 3'd1, 10'd11);
		plan_pred(KIND_INS_HEAD, 3'd1, 10'd12);
		plan_pred(KIND_RM_ITEM,  3'd1, 10'd10);
		plan_pred(KIND_RM_ITEM,  3'd1, 10'd1023);
		plan_pred(KIND_RM_TAIL,  3'd1, 10'd0);
		// node shared by two lists leaves a nil tail link behind
		plan_pred(KIND_INS_TAIL, 3'd2, 10'd20);
		plan_pred(KIND_INS_TAIL, 3'd3, 10'd20);
		plan_pred(KIND_RM_HEAD,  3'd3, 10'd0);
		plan_pred(KIND_RM_TAIL,  3'd2, 10'd0);
		plan_pred(KIND_RM_HEAD,  3'd2, 10'd0);
		plan_pred(KIND_INS_HEAD, 3'd6, 10'd682);
		plan_pred(KIND_INS_TAIL, 3'd5, 10'd341);
	endtask

	// main stimulus
	initial begin : stimulus
		kind_t k;
		list_t l;
		idx_t  ix;
		bit    counted;
		int    left;
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		kind       = KIND_INS_HEAD;
		list_id    = '0;
		item_index = '0;
		cfg_valid  = 1'b0;
		cfg_data   = '0;
		errors     = 0;
		in_burst   = 0;
		phase_limits = '{11'd4, 11'd0, 11'd1, 11'd2047, 11'd16, MAX_SIZE_RESET};
		reset_predictor();
		build_plan();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		foreach (plan_q[i]) send_item(plan_q[i].k, plan_q[i].l, plan_q[i].ix, plan_q[i].known,
		                              plan_q[i].res);
		in_valid <= 1'b0;

		// random phases, one size limit each
		foreach (phase_limits[p]) begin
			write_limit(phase_limits[p]);
			left = PHASE_ITEMS;
			while (left > 0) begin
				pick_item(k, l, ix, counted);
				send_item(k, l, ix, 1'b0, '0);
				if (counted) left--;
			end
			in_valid <= 1'b0;
		end

		// drain, then a short tail for stray results
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// compare one accepted result item with the oldest expectation
	task automatic check_result();
		result_t want;
		if (pending_results.size() == 0) begin
			$display("%0t: result item with nothing expected, removed_index %0d status %0d",
			         $time, removed_index, status);
			errors++;
			return;
		end
		want = pending_results.pop_front();
		if (removed_index !== want.removed_index) begin
			$display("%0t: removed_index expected %0d actual %0d", $time,
			         want.removed_index, removed_index);
			errors++;
		end
		if (removed_valid !== want.removed_valid) begin
			$display("%0t: removed_valid expected %0d actual %0d", $time,
			         want.removed_valid, removed_valid);
			errors++;
		end
		if (status !== want.status) begin
			$display("%0t: status expected %0d actual %0d", $time, want.status, status);
			errors++;
		end
		if (list_size !== want.list_size) begin
			$display("%0t: list_size expected %0d actual %0d", $time, want.list_size, list_size);
			errors++;
		end
	endtask

	// result side: check accepted items and stall at random
	initial begin : result_side
		int stall_left;
		int out_burst;
		int len;
		out_stall  = 1'b0;
		stall_left = 0;
		out_burst  = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) check_result();
			if (stall_left > 0) begin
				stall_left--;
			end else if (out_stall) begin
				out_stall <= 1'b0;
				stall_left = $urandom_range(0, 6);
			end else begin
				draw_idle(out_burst, len);
				if (len > 0) begin
					out_stall <= 1'b1;
					stall_left = len - 1;
				end
			end
		end
	end

	// watchdog on cycles with no handshake on any channel
	initial begin : watchdog
		int quiet;
		quiet = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= WATCHDOG_LIMIT) begin
				$display("%0t: no handshake for %0d cycles", $time, quiet);
				$display("Verification failed");
				$finish;
			end
		end
	end

endmodule

// File: filelist.f
rtl/core/idll_pkg.sv
rtl/core/idll_ram.sv
rtl/core/idll_ctrl.sv
rtl/core/indexed_doubly_linked_list_manager.sv
rtl/core/idll_checker.sv
bench/indexed_doubly_linked_list_manager_tb.sv
